// File: rtl/rcd_pkg.sv
// Shared types, constants and arithmetic helpers for the radial curvature block.
package rcd_pkg;

  // Configuration register indexes
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_CAMERA    = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 1'b1;
  localparam int CFG_DW = 48;

  // Square root unit: radicand width and root bits
  localparam int SQ_XW = 63;
  localparam int SQ_RW = 31;

  // Divider unit: numerator, denominator and quotient widths
  localparam int DIV_NW = 62;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 30;

  typedef struct packed {
    logic [47:0]        vertex_position;
    logic [47:0]        vertex_normal;
    logic [47:0]        principal_dir_one;
    logic [47:0]        principal_dir_two;
    logic signed [15:0] curvature_one;
    logic signed [15:0] curvature_two;
    logic signed [15:0] deriv_term_a;
    logic signed [15:0] deriv_term_b;
    logic signed [15:0] deriv_term_c;
    logic signed [15:0] deriv_term_d;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] radial_curvature;
    logic signed [31:0] deriv_numerator;
    logic signed [15:0] deriv_denominator;
    logic               degenerate;
  } out_item_t;

  // Per-vertex data that rides along the view normalization
  typedef struct packed {
    logic               l2zero;
    logic [47:0]        normal;
    logic [47:0]        dir_one;
    logic [47:0]        dir_two;
    logic signed [15:0] k1;
    logic signed [15:0] k2;
    logic signed [15:0] ta;
    logic signed [15:0] tb;
    logic signed [15:0] tc;
    logic signed [15:0] td;
  } vec_t;

  typedef struct packed {
    vec_t               vec;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
  } sq_side_t;

  typedef struct packed {
    vec_t       vec;
    logic [2:0] neg;
  } view_side_t;

  typedef struct packed {
    vec_t               vec;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } mid_t;

  typedef struct packed {
    logic               l2zero;
    logic               szero;
    logic               p_neg;
    logic               t_neg;
    logic signed [15:0] ndotv;
    logic signed [31:0] kr;
    logic signed [26:0] h;
  } tail_side_t;

  localparam int SIDE_W = $bits(sq_side_t);
  typedef logic [SIDE_W-1:0] side_t;

  // Signed 16-bit lane k of a packed triple
  function automatic logic signed [15:0] lane16(input logic [47:0] p, input int unsigned k);
    return $signed(p[16*k +: 16]);
  endfunction

  // Shift right with round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] n,
                                                  input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = n[63] ? 64'(-n) : 64'(n);
    r = (mag + (64'(1) << (sh - 1))) >> sh;
    return n[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sh7FFF) return 16'sh7FFF;
    else if (v < -64'sh8000) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// File: rtl/rcd_if.sv
// Valid/ready channel interfaces for vertex items and result items.
interface rcd_in_if;
  logic               valid;
  logic               ready;
  logic [47:0]        vertex_position;
  logic [47:0]        vertex_normal;
  logic [47:0]        principal_dir_one;
  logic [47:0]        principal_dir_two;
  logic signed [15:0] curvature_one;
  logic signed [15:0] curvature_two;
  logic signed [15:0] deriv_term_a;
  logic signed [15:0] deriv_term_b;
  logic signed [15:0] deriv_term_c;
  logic signed [15:0] deriv_term_d;

  modport source (
    output valid, vertex_position, vertex_normal, principal_dir_one, principal_dir_two,
    output curvature_one, curvature_two, deriv_term_a, deriv_term_b, deriv_term_c,
    output deriv_term_d,
    input  ready
  );
  modport sink (
    input  valid, vertex_position, vertex_normal, principal_dir_one, principal_dir_two,
    input  curvature_one, curvature_two, deriv_term_a, deriv_term_b, deriv_term_c,
    input  deriv_term_d,
    output ready
  );
endinterface

interface rcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] radial_curvature;
  logic signed [31:0] deriv_numerator;
  logic signed [15:0] deriv_denominator;
  logic               degenerate;

  modport source (
    output valid, radial_curvature, deriv_numerator, deriv_denominator, degenerate,
    input  ready
  );
  modport sink (
    input  valid, radial_curvature, deriv_numerator, deriv_denominator, degenerate,
    output ready
  );
endinterface

// File: rtl/rcd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rcd_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [rcd_pkg::SQ_XW-1:0] radicand,
  input  rcd_pkg::side_t           in_side,
  output logic                     out_valid,
  output logic [rcd_pkg::SQ_RW-1:0] root,
  output rcd_pkg::side_t           out_side
);
  import rcd_pkg::*;

  logic             vld  [SQ_RW];
  logic [SQ_XW-1:0] rem  [SQ_RW];
  logic [SQ_RW-1:0] rt   [SQ_RW];
  side_t            sd   [SQ_RW];

  for (genvar k = 0; k < SQ_RW; k++) begin : g_stage
    localparam int B = SQ_RW - 1 - k;
    logic             p_valid;
    logic [SQ_XW-1:0] p_rem;
    logic [SQ_RW-1:0] p_root;
    side_t            p_side;
    logic [SQ_XW-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = radicand;
      assign p_root  = '0;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = vld[k-1];
      assign p_rem   = rem[k-1];
      assign p_root  = rt[k-1];
      assign p_side  = sd[k-1];
    end

    // Try setting this root bit: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (SQ_XW'(p_root) << (B + 1)) | (SQ_XW'(1) << (2 * B));
    assign take  = p_rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? p_rem - trial : p_rem;
        rt[k]  <= take ? (p_root | (SQ_RW'(1) << B)) : p_root;
        sd[k]  <= p_side;
      end
    end
  end

  assign out_valid = vld[SQ_RW-1];
  assign root      = rt[SQ_RW-1];
  assign out_side  = sd[SQ_RW-1];

endmodule

// File: rtl/rcd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rcd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rcd_pkg::DIV_NW-1:0] num,
  input  logic [rcd_pkg::DIV_DW-1:0] den,
  input  rcd_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [rcd_pkg::DIV_QW-1:0] quot,
  output rcd_pkg::side_t             out_side
);
  import rcd_pkg::*;

  logic              vld [DIV_QW];
  logic [DIV_NW-1:0] rem [DIV_QW];
  logic [DIV_DW-1:0] dv  [DIV_QW];
  logic [DIV_QW-1:0] qt  [DIV_QW];
  side_t             sd  [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
    localparam int B = DIV_QW - 1 - k;
    logic              p_valid;
    logic [DIV_NW-1:0] p_rem;
    logic [DIV_DW-1:0] p_den;
    logic [DIV_QW-1:0] p_quot;
    side_t             p_side;
    logic [DIV_NW-1:0] sub;
    logic              take;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = num;
      assign p_den   = den;
      assign p_quot  = '0;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = vld[k-1];
      assign p_rem   = rem[k-1];
      assign p_den   = dv[k-1];
      assign p_quot  = qt[k-1];
      assign p_side  = sd[k-1];
    end

    // Subtract the shifted divisor when it fits
    assign sub  = DIV_NW'(p_den) << B;
    assign take = p_rem >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? p_rem - sub : p_rem;
        dv[k]  <= p_den;
        qt[k]  <= take ? (p_quot | (DIV_QW'(1) << B)) : p_quot;
        sd[k]  <= p_side;
      end
    end
  end

  assign out_valid = vld[DIV_QW-1];
  assign quot      = qt[DIV_QW-1];
  assign out_side  = sd[DIV_QW-1];

endmodule

// File: rtl/rcd_view.sv
// View vector: difference to camera, length, and normalization to Q1.14.
module rcd_view (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  rcd_pkg::in_item_t in_item,
  input  logic [47:0]       camera,
  output logic              out_valid,
  output rcd_pkg::mid_t     out_mid
);
  import rcd_pkg::*;

  // Stage A: camera minus vertex
  logic               a_valid;
  vec_t               a_vec;
  logic signed [16:0] a_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_d[k] <= 17'(lane16(camera, k)) - 17'(lane16(in_item.vertex_position, k));
      end
      a_vec.l2zero  <= 1'b0;
      a_vec.normal  <= in_item.vertex_normal;
      a_vec.dir_one <= in_item.principal_dir_one;
      a_vec.dir_two <= in_item.principal_dir_two;
      a_vec.k1      <= in_item.curvature_one;
      a_vec.k2      <= in_item.curvature_two;
      a_vec.ta      <= in_item.deriv_term_a;
      a_vec.tb      <= in_item.deriv_term_b;
      a_vec.tc      <= in_item.deriv_term_c;
      a_vec.td      <= in_item.deriv_term_d;
    end
  end

  // Stage B: squares
  logic               b_valid;
  vec_t               b_vec;
  logic signed [16:0] b_d [3];
  logic [32:0]        b_sq [3];
  logic signed [33:0] sq_full [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_full[k] = 34'(a_d[k]) * 34'(a_d[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b_sq[k] <= sq_full[k][32:0];
        b_d[k]  <= a_d[k];
      end
      b_vec <= a_vec;
    end
  end

  // Stage C: squared length
  logic        c_valid;
  sq_side_t    c_side;
  logic [33:0] c_l2;
  logic [33:0] l2_sum;
  vec_t        c_vec_next;

  assign l2_sum = 34'(b_sq[0]) + 34'(b_sq[1]) + 34'(b_sq[2]);

  // Mark a camera sitting on the vertex
  always_comb begin
    c_vec_next        = b_vec;
    c_vec_next.l2zero = (l2_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_l2       <= l2_sum;
      c_side.vec <= c_vec_next;
      c_side.dx  <= b_d[0];
      c_side.dy  <= b_d[1];
      c_side.dz  <= b_d[2];
    end
  end

  // Length in Q.14: floor(sqrt(L2 * 2^28))
  logic             sq_valid;
  logic [SQ_RW-1:0] sq_root;
  side_t            sq_side_raw;
  sq_side_t         sq_side;

  rcd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .radicand ({1'b0, c_l2, 28'd0}),
    .in_side  (SIDE_W'(c_side)),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_side (sq_side_raw)
  );

  assign sq_side = sq_side_t'(sq_side_raw);

  // Stage D: rounded dividend |d| * 2^28 + s/2 per axis
  logic               d_valid;
  logic [DIV_NW-1:0]  d_num [3];
  logic [DIV_DW-1:0]  d_den;
  view_side_t         d_side;
  logic signed [16:0] dsel [3];
  logic [16:0]        dmag [3];

  always_comb begin
    dsel[0] = sq_side.dx;
    dsel[1] = sq_side.dy;
    dsel[2] = sq_side.dz;
    for (int k = 0; k < 3; k++) begin
      dmag[k] = dsel[k][16] ? 17'(-dsel[k]) : 17'(dsel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_num[k]      <= DIV_NW'({dmag[k], 28'd0}) + DIV_NW'(sq_root >> 1);
        d_side.neg[k] <= dsel[k][16];
      end
      d_den      <= DIV_DW'(sq_root);
      d_side.vec <= sq_side.vec;
    end
  end

  // Three dividers; the first carries the rest of the vertex
  logic              dv_valid;
  logic [DIV_QW-1:0] dv_quot [3];
  side_t             dv_side_raw;
  view_side_t        dv_side;

  rcd_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .num      (d_num[0]),
    .den      (d_den),
    .in_side  (SIDE_W'(d_side)),
    .out_valid(dv_valid),
    .quot     (dv_quot[0]),
    .out_side (dv_side_raw)
  );

  rcd_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .num      (d_num[1]),
    .den      (d_den),
    .in_side  ('0),
    .out_valid(),
    .quot     (dv_quot[1]),
    .out_side ()
  );

  rcd_div u_div_z (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .num      (d_num[2]),
    .den      (d_den),
    .in_side  ('0),
    .out_valid(),
    .quot     (dv_quot[2]),
    .out_side ()
  );

  assign dv_side = view_side_t'(dv_side_raw[$bits(view_side_t)-1:0]);

  // Stage E: apply signs
  logic signed [15:0] vsig [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsig[k] = dv_side.neg[k] ? -16'(dv_quot[k]) : 16'(dv_quot[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mid.vec <= dv_side.vec;
      out_mid.vx  <= vsig[0];
      out_mid.vy  <= vsig[1];
      out_mid.vz  <= vsig[2];
    end
  end

endmodule

// File: rtl/rcd_curv.sv
// Projections, radial curvature and thresholded derivative numerator.
module rcd_curv (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rcd_pkg::mid_t      in_mid,
  input  logic signed [15:0] threshold,
  output logic               out_valid,
  output rcd_pkg::out_item_t out_item
);
  import rcd_pkg::*;

  // Stage F: nine lane products
  logic               f_valid;
  logic signed [31:0] f_pr [9];
  vec_t               f_vec;
  logic signed [15:0] view_l [3];
  logic [47:0]        vecs [3];

  always_comb begin
    view_l[0] = in_mid.vx;
    view_l[1] = in_mid.vy;
    view_l[2] = in_mid.vz;
    vecs[0]   = in_mid.vec.normal;
    vecs[1]   = in_mid.vec.dir_one;
    vecs[2]   = in_mid.vec.dir_two;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          f_pr[3*j+k] <= 32'(view_l[k]) * 32'(lane16(vecs[j], k));
        end
      end
      f_vec <= in_mid.vec;
    end
  end

  // Stage G: dot products, rounded to Q1.14
  logic               g_valid;
  vec_t               g_vec;
  logic signed [15:0] g_dot [3];
  logic signed [33:0] dsum [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dsum[j] = 34'(f_pr[3*j]) + 34'(f_pr[3*j+1]) + 34'(f_pr[3*j+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        g_dot[j] <= sat16(rnd_shr(64'(dsum[j]), 14));
      end
      g_vec <= f_vec;
    end
  end

  // Stage H: second-order products
  logic               h_valid;
  logic               h_l2zero;
  logic signed [15:0] h_nd, h_k1, h_k2;
  logic signed [31:0] h_uu, h_tt, h_ut, h_ua, h_tb, h_uc, h_td, h_thn;
  logic signed [16:0] h_kd;

  always_ff @(posedge clk) begin
    if (en) begin
      h_uu     <= 32'(g_dot[1]) * 32'(g_dot[1]);
      h_tt     <= 32'(g_dot[2]) * 32'(g_dot[2]);
      h_ut     <= 32'(g_dot[1]) * 32'(g_dot[2]);
      h_ua     <= 32'(g_dot[1]) * 32'(g_vec.ta);
      h_tb     <= 32'(g_dot[2]) * 32'(g_vec.tb);
      h_uc     <= 32'(g_dot[1]) * 32'(g_vec.tc);
      h_td     <= 32'(g_dot[2]) * 32'(g_vec.td);
      h_thn    <= 32'(threshold) * 32'(g_dot[0]);
      h_kd     <= 17'(g_vec.k2) - 17'(g_vec.k1);
      h_nd     <= g_dot[0];
      h_k1     <= g_vec.k1;
      h_k2     <= g_vec.k2;
      h_l2zero <= g_vec.l2zero;
    end
  end

  // Stage I: curvature terms, S, rounded squares, inner sums
  logic               i_valid;
  logic               i_l2zero;
  logic signed [15:0] i_nd;
  logic signed [47:0] i_kuu, i_ktt;
  logic [31:0]        i_s;
  logic signed [17:0] i_u2q, i_v2q;
  logic signed [33:0] i_in1, i_in2;
  logic signed [48:0] i_ktr;
  logic signed [26:0] i_h;
  logic [32:0]        s_sum;

  assign s_sum = 33'(h_uu) + 33'(h_tt);

  always_ff @(posedge clk) begin
    if (en) begin
      i_kuu    <= 48'(h_k1) * 48'(h_uu);
      i_ktt    <= 48'(h_k2) * 48'(h_tt);
      i_s      <= s_sum[31:0];
      i_u2q    <= 18'(rnd_shr(64'(h_uu), 14));
      i_v2q    <= 18'(rnd_shr(64'(h_tt), 14));
      i_in1    <= 34'(h_ua) + 34'(h_tb) + (34'(h_tb) <<< 1);
      i_in2    <= 34'(h_uc) + (34'(h_uc) <<< 1) + 34'(h_td);
      i_ktr    <= 49'(h_kd) * 49'(h_ut);
      i_h      <= 27'(rnd_shr(64'(h_thn), 6));
      i_nd     <= h_nd;
      i_l2zero <= h_l2zero;
    end
  end

  // Stage J: radial curvature and weighted inner sums
  logic               j_valid;
  logic               j_l2zero, j_szero;
  logic signed [15:0] j_nd;
  logic signed [31:0] j_kr;
  logic signed [51:0] j_pa, j_pb;
  logic signed [48:0] j_ktr;
  logic [31:0]        j_s;
  logic signed [26:0] j_h;

  always_ff @(posedge clk) begin
    if (en) begin
      j_kr     <= sat32(rnd_shr(64'(i_kuu) + 64'(i_ktt), 20));
      j_pa     <= 52'(i_u2q) * 52'(i_in1);
      j_pb     <= 52'(i_v2q) * 52'(i_in2);
      j_ktr    <= i_ktr;
      j_s      <= i_s;
      j_szero  <= (i_s == '0);
      j_h      <= i_h;
      j_nd     <= i_nd;
      j_l2zero <= i_l2zero;
    end
  end

  // Stage K: numerator sum
  logic               k_valid;
  tail_side_t         k_side;
  logic signed [52:0] k_pn;
  logic signed [48:0] k_ktr;
  logic [31:0]        k_s;

  always_ff @(posedge clk) begin
    if (en) begin
      k_pn          <= 53'(j_pa) + 53'(j_pb);
      k_ktr         <= j_ktr;
      k_s           <= j_s;
      k_side.l2zero <= j_l2zero;
      k_side.szero  <= j_szero;
      k_side.p_neg  <= 1'b0;
      k_side.t_neg  <= 1'b0;
      k_side.ndotv  <= j_nd;
      k_side.kr     <= j_kr;
      k_side.h      <= j_h;
    end
  end

  // Stage L: rounded dividends for p and tr
  logic              l_valid;
  tail_side_t        l_side;
  tail_side_t        l_side_next;
  logic [DIV_NW-1:0] l_pnum, l_tnum;
  logic [DIV_DW-1:0] l_den;
  logic [52:0]       pmag;
  logic [48:0]       tmag;

  assign pmag = k_pn[52] ? 53'(-k_pn) : 53'(k_pn);
  assign tmag = k_ktr[48] ? 49'(-k_ktr) : 49'(k_ktr);

  // Record the signs stripped from both dividends
  always_comb begin
    l_side_next       = k_side;
    l_side_next.p_neg = k_pn[52];
    l_side_next.t_neg = k_ktr[48];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_pnum <= DIV_NW'({pmag, 8'd0}) + DIV_NW'(k_s >> 1);
      l_tnum <= DIV_NW'({tmag, 8'd0}) + DIV_NW'(k_s >> 1);
      l_den  <= DIV_DW'(k_s);
      l_side <= l_side_next;
    end
  end

  // Divide both by S
  logic              dv_valid;
  logic [DIV_QW-1:0] qp, qt;
  side_t             dv_side_raw;
  tail_side_t        dv_side;

  rcd_div u_div_p (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (l_valid),
    .num      (l_pnum),
    .den      (l_den),
    .in_side  (SIDE_W'(l_side)),
    .out_valid(dv_valid),
    .quot     (qp),
    .out_side (dv_side_raw)
  );

  rcd_div u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (l_valid),
    .num      (l_tnum),
    .den      (l_den),
    .in_side  ('0),
    .out_valid(),
    .quot     (qt),
    .out_side ()
  );

  assign dv_side = tail_side_t'(dv_side_raw[$bits(tail_side_t)-1:0]);

  // Stage M: signed p and tr
  logic               m_valid;
  tail_side_t         m_side;
  logic signed [31:0] m_p;
  logic signed [24:0] m_tr;

  always_ff @(posedge clk) begin
    if (en) begin
      m_p    <= dv_side.p_neg ? -32'(qp) : 32'(qp);
      m_tr   <= dv_side.t_neg ? -25'(qt) : 25'(qt);
      m_side <= dv_side;
    end
  end

  // Stage N: tr squared
  logic               n_valid;
  tail_side_t         n_side;
  logic signed [31:0] n_p;
  logic [46:0]        n_trsq;
  logic signed [49:0] trsq_full;

  assign trsq_full = 50'(m_tr) * 50'(m_tr);

  always_ff @(posedge clk) begin
    if (en) begin
      n_trsq <= trsq_full[46:0];
      n_p    <= m_p;
      n_side <= m_side;
    end
  end

  // Stage O: ndotv times tr^2 as two partial products
  logic               o_valid;
  tail_side_t         o_side;
  logic signed [31:0] o_p;
  logic signed [40:0] o_ql;
  logic signed [39:0] o_qh;

  always_ff @(posedge clk) begin
    if (en) begin
      o_ql   <= 41'(n_side.ndotv) * 41'($signed({1'b0, n_trsq[23:0]}));
      o_qh   <= 40'(n_side.ndotv) * 40'($signed({1'b0, n_trsq[46:24]}));
      o_p    <= n_p;
      o_side <= n_side;
    end
  end

  // Stage P: combine and round q
  logic               p_valid;
  tail_side_t         p_side;
  logic signed [31:0] p_p;
  logic signed [34:0] p_q;
  logic signed [63:0] qsum;

  assign qsum = (64'(o_qh) <<< 24) + 64'(o_ql);

  always_ff @(posedge clk) begin
    if (en) begin
      p_q    <= 35'(rnd_shr(qsum <<< 1, 30));
      p_p    <= o_p;
      p_side <= o_side;
    end
  end

  // Stage Q: final numerator and degenerate masking
  out_item_t          res;
  logic signed [63:0] num_full;

  assign num_full = 64'(p_p) - 64'(p_q) - 64'(p_side.h);

  always_comb begin
    res.radial_curvature  = p_side.kr;
    res.deriv_numerator   = sat32(num_full);
    res.deriv_denominator = p_side.ndotv;
    res.degenerate        = 1'b0;
    if (p_side.l2zero) begin
      res.radial_curvature  = '0;
      res.deriv_numerator   = '0;
      res.deriv_denominator = '0;
      res.degenerate        = 1'b1;
    end else if (p_side.szero) begin
      res.deriv_numerator = '0;
      res.degenerate      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= res;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      h_valid   <= 1'b0;
      i_valid   <= 1'b0;
      j_valid   <= 1'b0;
      k_valid   <= 1'b0;
      l_valid   <= 1'b0;
      m_valid   <= 1'b0;
      n_valid   <= 1'b0;
      o_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_valid   <= in_valid;
      g_valid   <= f_valid;
      h_valid   <= g_valid;
      i_valid   <= h_valid;
      j_valid   <= i_valid;
      k_valid   <= j_valid;
      l_valid   <= k_valid;
      m_valid   <= dv_valid;
      n_valid   <= m_valid;
      o_valid   <= n_valid;
      p_valid   <= o_valid;
      out_valid <= p_valid;
    end
  end

endmodule

// File: rtl/radial_curvature_derivative_top.sv
// Top level: configuration registers, stall control and the two pipeline halves.
//
// Computes, per mesh vertex, the normalized view ndotv, the radial curvature
// and the suggestive-contour derivative numerator. A vertex is taken every
// clock cycle while the output is not stalled. Each vertex passes through the
// view difference and length, the bit-per-stage square root, the view
// division (one quotient bit per stage, 30 stages) with its setup and sign
// stages, the projections and products, the division by u^2+t^2, and the
// final terms ending in the output register. The whole pipeline holds while
// a result waits to be taken. The user must write camera position and
// threshold through the configuration port only while no vertex is in
// flight; the block itself does not enforce this.
module radial_curvature_derivative_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rcd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rcd_pkg::CFG_DW-1:0] cfg_data,
  rcd_in_if.sink                     vertex,
  rcd_out_if.source                  result
);
  import rcd_pkg::*;

  // Configuration registers
  logic [47:0]        camera;
  logic signed [15:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera    <= '0;
      threshold <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA:    camera    <= cfg_data[47:0];
        CFG_THRESHOLD: threshold <= $signed(cfg_data[15:0]);
        default:       ;
      endcase
    end
  end

  // Advance everything unless the output holds an untaken transaction
  logic en;
  assign en           = !result.valid || result.ready;
  assign vertex.ready = en;

  in_item_t item;
  always_comb begin
    item.vertex_position   = vertex.vertex_position;
    item.vertex_normal     = vertex.vertex_normal;
    item.principal_dir_one = vertex.principal_dir_one;
    item.principal_dir_two = vertex.principal_dir_two;
    item.curvature_one     = vertex.curvature_one;
    item.curvature_two     = vertex.curvature_two;
    item.deriv_term_a      = vertex.deriv_term_a;
    item.deriv_term_b      = vertex.deriv_term_b;
    item.deriv_term_c      = vertex.deriv_term_c;
    item.deriv_term_d      = vertex.deriv_term_d;
  end

  logic      mid_valid;
  mid_t      mid;
  out_item_t res;

  rcd_view u_view (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vertex.valid),
    .in_item  (item),
    .camera   (camera),
    .out_valid(mid_valid),
    .out_mid  (mid)
  );

  rcd_curv u_curv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (mid_valid),
    .in_mid   (mid),
    .threshold(threshold),
    .out_valid(result.valid),
    .out_item (res)
  );

  assign result.radial_curvature  = res.radial_curvature;
  assign result.deriv_numerator   = res.deriv_numerator;
  assign result.deriv_denominator = res.deriv_denominator;
  assign result.degenerate        = res.degenerate;

endmodule
